// File: hw/rtl/slid_pkg.sv
package slid_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_W     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // fixed field widths on the stream ports
    localparam int MODE_W    = 2;
    localparam int IN_KEY_W  = 64;
    localparam int RANK_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int OUT_KEY_W = 64;
    localparam int OUT_CNT_W = 7;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 80;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_RANK_RANGE = 2'd2,
        ST_UNUSED     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_RD_DATA,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/sorted_list_insert_delete.sv
// Sorted key store: one compare unit walks a single-port-read RAM under a small sequencer.
// An insert walks down from the top, shifting each larger entry up one slot, and writes the key
// where the walk stops; a delete scans every held entry; a read does one RAM read; a full store,
// a bad rank or the unused mode goes straight to the result; any item waits while the sink holds the output register.
// One item at a time; input is ready again the cycle after the result is registered.
// Reset (i_rst_n low, synchronous) empties the store; RAM contents are not cleared.
module sorted_list_insert_delete (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // key[63:0], rank[69:64], from_largest[70], zero pad[71]
    input  logic [slid_pkg::S_DATA_W-1:0]  i_s_tdata,
    // mode[1:0]
    input  logic [slid_pkg::MODE_W-1:0]    i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // read_key[63:0], removed[70:64], held[77:71], zero pad[79:78]
    output logic [slid_pkg::M_DATA_W-1:0]  o_m_tdata,
    // status[1:0]
    output logic [slid_pkg::STATUS_W-1:0]  o_m_tuser
);

    localparam int ADDR_W = slid_pkg::ADDR_W;
    localparam int CNT_W  = slid_pkg::CNT_W;
    localparam int KEY_W  = slid_pkg::KEY_W;

    // control state
    slid_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // item and work registers
    slid_pkg::t_mode   r_mode, n_mode;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [slid_pkg::RANK_W-1:0] r_rank, n_rank;
    logic              r_from_largest, n_from_largest;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_kept, n_kept;
    slid_pkg::t_status r_res_status, n_res_status;
    logic [KEY_W-1:0]  r_res_key, n_res_key;
    logic [CNT_W-1:0]  r_res_removed, n_res_removed;

    // output register
    slid_pkg::t_status r_out_status, n_out_status;
    logic [slid_pkg::OUT_KEY_W-1:0] r_out_key, n_out_key;
    logic [slid_pkg::OUT_CNT_W-1:0] r_out_removed, n_out_removed;
    logic [slid_pkg::OUT_CNT_W-1:0] r_out_held, n_out_held;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;

    logic              in_fire;
    logic [CNT_W-1:0]  rank_ext;
    logic [CNT_W-1:0]  read_idx;
    logic [CNT_W-1:0]  pos_m1;

    slid_ram #(
        .WIDTH (KEY_W),
        .DEPTH (slid_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == slid_pkg::S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign rank_ext = CNT_W'(r_rank);
    assign read_idx = r_from_largest ? (r_count - CNT_W'(1) - rank_ext) : rank_ext;
    assign pos_m1   = r_pos - CNT_W'(1);

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_out_valid    = r_out_valid;
        n_mode         = r_mode;
        n_key          = r_key;
        n_rank         = r_rank;
        n_from_largest = r_from_largest;
        n_pos          = r_pos;
        n_kept         = r_kept;
        n_res_status   = r_res_status;
        n_res_key      = r_res_key;
        n_res_removed  = r_res_removed;
        n_out_status   = r_out_status;
        n_out_key      = r_out_key;
        n_out_removed  = r_out_removed;
        n_out_held     = r_out_held;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = r_key;
        ram_raddr      = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            slid_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_mode         = slid_pkg::t_mode'(i_s_tuser);
                    n_key          = i_s_tdata[KEY_W-1:0];
                    n_rank         = i_s_tdata[69:64];
                    n_from_largest = i_s_tdata[70];
                    n_state        = slid_pkg::S_DISPATCH;
                end
            end
            slid_pkg::S_DISPATCH: begin
                n_res_status  = slid_pkg::ST_DONE;
                n_res_key     = '0;
                n_res_removed = '0;
                n_pos         = r_count;
                n_kept        = '0;
                unique case (r_mode)
                    slid_pkg::MODE_INSERT: begin
                        if (r_count >= CNT_W'(slid_pkg::DEPTH)) begin
                            n_res_status = slid_pkg::ST_FULL;
                            n_state      = slid_pkg::S_DONE;
                        end else begin
                            n_state = slid_pkg::S_INS_RD;
                        end
                    end
                    slid_pkg::MODE_DELETE: begin
                        n_pos   = '0;   // scan index
                        n_state = slid_pkg::S_DEL_RD;
                    end
                    slid_pkg::MODE_READ: begin
                        if (rank_ext >= r_count) begin
                            n_res_status = slid_pkg::ST_RANK_RANGE;
                            n_state      = slid_pkg::S_DONE;
                        end else begin
                            ram_raddr = read_idx[ADDR_W-1:0];
                            n_state   = slid_pkg::S_RD_DATA;
                        end
                    end
                    default: begin
                        n_state = slid_pkg::S_DONE;
                    end
                endcase
            end
            slid_pkg::S_INS_RD: begin
                if (r_pos == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = r_key;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = slid_pkg::S_DONE;
                end else begin
                    ram_raddr = pos_m1[ADDR_W-1:0];
                    n_state   = slid_pkg::S_INS_CMP;
                end
            end
            slid_pkg::S_INS_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[ADDR_W-1:0];
                if (ram_rdata > r_key) begin
                    // shift the larger entry up one slot and keep walking down
                    ram_wdata = ram_rdata;
                    n_pos     = pos_m1;
                    n_state   = slid_pkg::S_INS_RD;
                end else begin
                    ram_wdata = r_key;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = slid_pkg::S_DONE;
                end
            end
            slid_pkg::S_DEL_RD: begin
                if (r_pos == r_count) begin
                    n_res_removed = r_count - r_kept;
                    n_count       = r_kept;
                    n_state       = slid_pkg::S_DONE;
                end else begin
                    ram_raddr = r_pos[ADDR_W-1:0];
                    n_state   = slid_pkg::S_DEL_CMP;
                end
            end
            slid_pkg::S_DEL_CMP: begin
                // compaction: kept never passes the scan index, so unread entries survive
                if (ram_rdata != r_key) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_kept[ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                    n_kept    = r_kept + CNT_W'(1);
                end
                n_pos   = r_pos + CNT_W'(1);
                n_state = slid_pkg::S_DEL_RD;
            end
            slid_pkg::S_RD_DATA: begin
                n_res_key = ram_rdata;
                n_state   = slid_pkg::S_DONE;
            end
            slid_pkg::S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_key     = slid_pkg::OUT_KEY_W'(r_res_key);
                    n_out_removed = slid_pkg::OUT_CNT_W'(r_res_removed);
                    n_out_held    = slid_pkg::OUT_CNT_W'(r_count);
                    n_state       = slid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slid_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slid_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode         <= n_mode;
        r_key          <= n_key;
        r_rank         <= n_rank;
        r_from_largest <= n_from_largest;
        r_pos          <= n_pos;
        r_kept         <= n_kept;
        r_res_status   <= n_res_status;
        r_res_key      <= n_res_key;
        r_res_removed  <= n_res_removed;
        r_out_status   <= n_out_status;
        r_out_key      <= n_out_key;
        r_out_removed  <= n_out_removed;
        r_out_held     <= n_out_held;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {2'b00, r_out_held, r_out_removed, r_out_key};

endmodule

// File: hw/rtl/slid_ram.sv
module slid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: dv/sorted_list_insert_delete_tb.sv
`timescale 1ns / 1ps

module sorted_list_insert_delete_tb;

    localparam int CLK_HALF    = 1;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 150;     // longer than a full-store delete
    localparam int RAND_ITEMS  = 1500;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        slid_pkg::t_status              status;
        logic [slid_pkg::OUT_KEY_W-1:0] read_key;
        logic [slid_pkg::OUT_CNT_W-1:0] removed;
        logic [slid_pkg::OUT_CNT_W-1:0] held;
    } t_list_reply;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    // key[63:0], rank[69:64], from_largest[70], pad[71]
    logic [slid_pkg::S_DATA_W-1:0] i_s_tdata;
    logic [slid_pkg::MODE_W-1:0]   i_s_tuser;   // mode[1:0]
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    // read_key[63:0], removed[70:64], held[77:71], pad
    logic [slid_pkg::M_DATA_W-1:0] o_m_tdata;
    logic [slid_pkg::STATUS_W-1:0] o_m_tuser;   // status[1:0]

    // software copy of the sorted store
    logic [slid_pkg::KEY_W-1:0] list_keys [slid_pkg::DEPTH];
    int                         list_count;
    t_list_reply                list_replies [$];
    logic [slid_pkg::KEY_W-1:0] key_pool [16];

    int errors;
    int cycles;
    int src_gap_max;
    int snk_stall_max;
    int snk_hold_req;

    sorted_list_insert_delete dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_list_insert_delete test failed");
            $finish;
        end
    end

    function automatic t_list_reply list_op(slid_pkg::t_mode mode,
                                            logic [slid_pkg::KEY_W-1:0] key,
                                            logic [slid_pkg::RANK_W-1:0] rank,
                                            logic from_largest);
        t_list_reply r;
        int pos;
        int kept;
        r.status   = slid_pkg::ST_DONE;
        r.read_key = '0;
        r.removed  = '0;
        case (mode)
            slid_pkg::MODE_INSERT: begin
                if (list_count >= slid_pkg::DEPTH) begin
                    r.status = slid_pkg::ST_FULL;
                end else begin
                    // new key lands after any equal keys
                    pos = list_count;
                    while (pos > 0 && list_keys[pos-1] > key) begin
                        list_keys[pos] = list_keys[pos-1];
                        pos--;
                    end
                    list_keys[pos] = key;
                    list_count++;
                end
            end
            slid_pkg::MODE_DELETE: begin
                kept = 0;
                for (int i = 0; i < list_count; i++) begin
                    if (list_keys[i] != key) begin
                        list_keys[kept] = list_keys[i];
                        kept++;
                    end
                end
                r.removed  = slid_pkg::OUT_CNT_W'(list_count - kept);
                list_count = kept;
            end
            slid_pkg::MODE_READ: begin
                if (int'(rank) >= list_count)
                    r.status = slid_pkg::ST_RANK_RANGE;
                else if (from_largest)
                    r.read_key = list_keys[list_count - 1 - int'(rank)];
                else
                    r.read_key = list_keys[rank];
            end
            default: ;
        endcase
        r.held = slid_pkg::OUT_CNT_W'(list_count);
        return r;
    endfunction

    task automatic send_item(slid_pkg::t_mode mode, logic [slid_pkg::KEY_W-1:0] key,
                             logic [slid_pkg::RANK_W-1:0] rank, logic from_largest);
        int gap;
        gap = (src_gap_max == 0) ? 0 : $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {1'b0, from_largest, rank, key};
        do @(posedge i_clk); while (!o_s_tready);
        list_replies.push_back(list_op(mode, key, rank, from_largest));
    endtask

    // sink: random stall before each result, or one long hold-off on request
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (snk_hold_req > 0) begin
                stall = snk_hold_req;
                snk_hold_req = 0;
            end else begin
                stall = (snk_stall_max == 0) ? 0 : $urandom_range(snk_stall_max, 0);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_list_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (list_replies.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: status %0d tdata %h", o_m_tuser, o_m_tdata);
            end else begin
                want = list_replies.pop_front();
                if (o_m_tuser !== want.status || o_m_tdata[63:0] !== want.read_key ||
                    o_m_tdata[70:64] !== want.removed || o_m_tdata[77:71] !== want.held) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: status %0d/%0d key %h/%h removed %0d/%0d held %0d/%0d",
                                 want.status, o_m_tuser, want.read_key, o_m_tdata[63:0],
                                 want.removed, o_m_tdata[70:64], want.held, o_m_tdata[77:71]);
                end
            end
        end
    end

    function automatic logic [slid_pkg::KEY_W-1:0] draw_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(15)];
        return {$urandom, $urandom};
    endfunction

    task automatic send_random_item();
        int pick;
        int ins_w;
        int del_w;
        logic [slid_pkg::KEY_W-1:0] key;
        logic [slid_pkg::RANK_W-1:0] rank;
        slid_pkg::t_mode mode;
        pick = $urandom_range(99);
        // steer the fill level so both empty and full regions get visited
        if (list_count >= 56) begin
            ins_w = 25; del_w = 35;
        end else if (list_count < 8) begin
            ins_w = 60; del_w = 10;
        end else begin
            ins_w = 42; del_w = 18;
        end
        if (pick < ins_w)
            mode = slid_pkg::MODE_INSERT;
        else if (pick < ins_w + del_w)
            mode = slid_pkg::MODE_DELETE;
        else if (pick < 95)
            mode = slid_pkg::MODE_READ;
        else
            mode = slid_pkg::MODE_NONE;
        key = draw_key();
        if (mode == slid_pkg::MODE_DELETE && list_count > 0 && $urandom_range(3) != 0)
            key = list_keys[$urandom_range(list_count - 1)];
        rank = slid_pkg::RANK_W'($urandom);
        if (mode == slid_pkg::MODE_READ && list_count > 0 && $urandom_range(4) != 0)
            rank = slid_pkg::RANK_W'($urandom_range(list_count - 1));
        send_item(mode, key, rank, 1'($urandom));
    endtask

    task automatic empty_store();
        while (list_count > 0)
            send_item(slid_pkg::MODE_DELETE, list_keys[0], '0, 1'b0);
    endtask

    task automatic test_directed();
        send_item(slid_pkg::MODE_READ,   '0,    '0,   1'b0);  // read on empty store
        send_item(slid_pkg::MODE_DELETE, 64'd5, '0,   1'b0);  // delete with no match
        send_item(slid_pkg::MODE_INSERT, '1,    '0,   1'b0);
        send_item(slid_pkg::MODE_INSERT, '0,    '0,   1'b0);
        send_item(slid_pkg::MODE_INSERT, 64'd5, '0,   1'b0);
        send_item(slid_pkg::MODE_INSERT, 64'd5, '1,   1'b1);
        send_item(slid_pkg::MODE_INSERT, 64'd7, '0,   1'b0);
        send_item(slid_pkg::MODE_INSERT, 64'd5, '0,   1'b0);
        send_item(slid_pkg::MODE_READ,   '0,    '0,   1'b0);
        send_item(slid_pkg::MODE_READ,   '1,    '0,   1'b1);
        send_item(slid_pkg::MODE_READ,   '0,    6'd3, 1'b1);
        send_item(slid_pkg::MODE_READ,   '0,    '1,   1'b1);  // rank out of range
        send_item(slid_pkg::MODE_READ,   '0,    6'd6, 1'b0);  // rank equal to count
        send_item(slid_pkg::MODE_READ,   '0,    6'd5, 1'b0);
        send_item(slid_pkg::MODE_NONE,   '1,    '1,   1'b1);  // unused mode
        send_item(slid_pkg::MODE_DELETE, 64'd5, '0,   1'b0);
        send_item(slid_pkg::MODE_DELETE, 64'd5, '0,   1'b0);
        send_item(slid_pkg::MODE_DELETE, '1,    '0,   1'b0);
        send_item(slid_pkg::MODE_INSERT, 64'h8000_0000_0000_0000, '0, 1'b0);
        send_item(slid_pkg::MODE_INSERT, 64'h7fff_ffff_ffff_ffff, '0, 1'b0);
        send_item(slid_pkg::MODE_READ,   '0,    6'd1, 1'b1);
        send_item(slid_pkg::MODE_READ,   '0,    6'd3, 1'b0);
        send_item(slid_pkg::MODE_DELETE, '0,    '0,   1'b0);
        send_item(slid_pkg::MODE_READ,   '0,    '0,   1'b1);
    endtask

    task automatic test_full_store();
        logic [slid_pkg::KEY_W-1:0] k;
        empty_store();
        k = {$urandom, $urandom};
        repeat (slid_pkg::DEPTH) send_item(slid_pkg::MODE_INSERT, k, '0, 1'b0);
        send_item(slid_pkg::MODE_INSERT, '0, '0, 1'b0);       // refused, store full
        send_item(slid_pkg::MODE_INSERT, '1, '0, 1'b0);
        send_item(slid_pkg::MODE_READ, '0, '1, 1'b0);
        send_item(slid_pkg::MODE_READ, '0, '1, 1'b1);
        send_item(slid_pkg::MODE_DELETE, k, '0, 1'b0);        // every entry goes
        repeat (slid_pkg::DEPTH) send_item(slid_pkg::MODE_INSERT, draw_key(), '0, 1'b0);
        send_item(slid_pkg::MODE_INSERT, draw_key(), '0, 1'b0);
        for (int r = 0; r < slid_pkg::DEPTH; r += 9)
            send_item(slid_pkg::MODE_READ, '0, slid_pkg::RANK_W'(r), 1'($urandom));
        send_item(slid_pkg::MODE_READ, '0, '1, 1'b0);
        send_item(slid_pkg::MODE_READ, '0, '1, 1'b1);
        empty_store();
    endtask

    task automatic test_random();
        for (int i = 0; i < RAND_ITEMS; i++) begin
            // rotate idling profile every 250 items, including stretches without gaps
            if (i % 250 == 0) begin
                case ((i / 250) % 4)
                    0: begin src_gap_max = 14; snk_stall_max = 14; end
                    1: begin src_gap_max = 0;  snk_stall_max = 0;  end
                    2: begin src_gap_max = 0;  snk_stall_max = 14; end
                    default: begin src_gap_max = 14; snk_stall_max = 0; end
                endcase
            end
            send_random_item();
        end
    endtask

    task automatic test_backpressure();
        src_gap_max   = 0;
        snk_stall_max = 0;
        snk_hold_req  = 400;
        repeat (20) send_random_item();
        src_gap_max   = 14;
        snk_stall_max = 14;
    endtask

    initial begin
        errors        = 0;
        cycles        = 0;
        list_count    = 0;
        src_gap_max   = 14;
        snk_stall_max = 14;
        snk_hold_req  = 0;
        key_pool[0]   = '0;
        key_pool[1]   = '1;
        for (int i = 2; i < 16; i++)
            key_pool[i] = (i < 8) ? slid_pkg::KEY_W'($urandom_range(20))
                                  : {$urandom, $urandom};
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= slid_pkg::MODE_INSERT;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_backpressure();
        test_random();
        test_backpressure();

        i_s_tvalid <= 1'b0;
        while (list_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && list_replies.size() == 0) begin
            $display("sorted_list_insert_delete test passed");
        end else begin
            $display("sorted_list_insert_delete test failed");
        end
        $finish;
    end

endmodule
